/* sv/run_length_glyph_decoder_assert.svh */
// Assertion macros for the run-length glyph decoder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef RUN_LENGTH_GLYPH_DECODER_ASSERT_SVH
`define RUN_LENGTH_GLYPH_DECODER_ASSERT_SVH

// Same-cycle implication
`define RLGD_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define RLGD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/rlgd_pkg.sv */
// Shared types and constants for the run-length glyph decoder.
// No dependencies.
package rlgd_pkg;

    localparam int HDR_LEN         = 5;
    localparam int INK_WIDTH_BITS  = 11;
    localparam int RUN_WIDTH_BITS  = 4;
    localparam int MAX_FIELD_BITS  = 32;
    localparam int MIN_OFFSET_BITS = 2;
    localparam int BYTE_ROUND      = 7;
    localparam int RUN_LEFT_W      = 15;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] ST_STARTED  = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_PIXEL    = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    localparam logic [2:0] FK_HDR    = 3'd0;
    localparam logic [2:0] FK_OFFSET = 3'd1;
    localparam logic [2:0] FK_COLOUR = 3'd2;
    localparam logic [2:0] FK_RCB    = 3'd3;
    localparam logic [2:0] FK_WIDTH  = 3'd4;
    localparam logic [2:0] FK_RUN    = 3'd5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        mem_address;
        logic [7:0]         mem_byte;
        logic [7:0]         glyph_code;
        logic               with_spacing;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [11:0]        advance_width;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               pixel_on;
        logic               final_pixel;
    } result_t;

    typedef struct packed {
        logic       capture;
        logic       write;
        logic       fetch_start;
        logic [2:0] fetch_kind;
        logic       set_ptr;
        logic       commit;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic fetch_done;
        logic hdr_last;
        logic reject;
        logic nbits_big;
        logic rcb_zero;
        logic active;
        logic need_run;
        logic slot_free;
    } sts_t;

endpackage

/* sv/rlgd_fetch.sv */
// Font byte store with an MSB-first bit reader that takes one read at a time.
// Depends on rlgd_pkg.
module rlgd_fetch
    import rlgd_pkg::*;
#(
    parameter int FONT_BYTES = 4096
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(FONT_BYTES)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          start,
    input  logic [$clog2(FONT_BYTES)+2:0] pos,
    input  logic [5:0]                    nbits,
    output logic                          done,
    output logic [31:0]                   value,
    output logic [$clog2(FONT_BYTES)+2:0] end_pos
);
    localparam int AW = $clog2(FONT_BYTES);
    localparam int PW = AW + 3;
    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_ISSUE = 2'd1;
    localparam logic [1:0] F_DATA  = 2'd2;

    logic [7:0]    mem [FONT_BYTES];
    logic [7:0]    rd_data_reg;
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [5:0]    left_reg, left_next;
    logic [31:0]   acc_reg, acc_next;
    logic          done_reg, done_next;
    logic [3:0]    avail;
    logic [3:0]    take;
    logic [7:0]    shifted;
    logic [7:0]    bits;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[pos_reg[PW-1:3]];
        end
    end

    always_comb
    begin
        avail   = 4'd8 - {1'b0, pos_reg[2:0]};
        take    = (left_reg < {2'b00, avail}) ? left_reg[3:0] : avail;
        shifted = rd_data_reg << pos_reg[2:0];
        bits    = shifted >> (4'd8 - take);
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    pos_next   = pos;
                    left_next  = nbits;
                    acc_next   = '0;
                    state_next = F_ISSUE;
                end
            end
            F_ISSUE:
            begin
                if (left_reg == 6'd0)
                begin
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    state_next = F_DATA;
                end
            end
            F_DATA:
            begin
                acc_next   = (acc_reg << take) | {24'd0, bits};
                pos_next   = pos_reg + PW'(take);
                left_next  = left_reg - {2'b00, take};
                state_next = F_ISSUE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign value   = acc_reg;
    assign end_pos = pos_reg;

endmodule

/* sv/rlgd_ctrl.sv */
// Sequencer for the run-length glyph decoder: walks the start and pixel steps.
// Depends on rlgd_pkg; drives rlgd_dp through cmd_t and reads sts_t.
module rlgd_ctrl
    import rlgd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] opcode,
    output logic       item_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HDR    = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_OFFSET = 4'd3;
    localparam logic [3:0] S_SETPTR = 4'd4;
    localparam logic [3:0] S_COLOUR = 4'd5;
    localparam logic [3:0] S_RCB    = 4'd6;
    localparam logic [3:0] S_WIDTH  = 4'd7;
    localparam logic [3:0] S_STEP   = 4'd8;
    localparam logic [3:0] S_RUN    = 4'd9;
    localparam logic [3:0] S_OUTW   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       wait_reg, wait_next;
    logic [1:0] res_reg, res_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        res_next   = res_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (opcode)
                        OP_WRITE: cmd.write = 1'b1;
                        OP_START:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_HDR;
                        end
                        OP_STEP:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR, S_OFFSET, S_COLOUR, S_RCB, S_RUN:
            begin
                if (!wait_reg)
                begin
                    cmd.fetch_start = 1'b1;
                    case (state_reg)
                        S_HDR:    cmd.fetch_kind = FK_HDR;
                        S_OFFSET: cmd.fetch_kind = FK_OFFSET;
                        S_COLOUR: cmd.fetch_kind = FK_COLOUR;
                        S_RCB:    cmd.fetch_kind = FK_RCB;
                        default:  cmd.fetch_kind = FK_RUN;
                    endcase
                    wait_next = 1'b1;
                end
                else if (sts.fetch_done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        S_HDR:    state_next = sts.hdr_last ? S_CHECK : S_HDR;
                        S_OFFSET: state_next = S_SETPTR;
                        S_COLOUR: state_next = S_RCB;
                        S_RCB:    state_next = S_WIDTH;
                        default:
                        begin
                            res_next   = ST_PIXEL;
                            state_next = S_OUTW;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (sts.reject)
                begin
                    res_next   = ST_REJECTED;
                    state_next = S_OUTW;
                end
                else
                begin
                    state_next = sts.nbits_big ? S_SETPTR : S_OFFSET;
                end
            end
            S_SETPTR:
            begin
                cmd.set_ptr = 1'b1;
                state_next  = S_COLOUR;
            end
            S_WIDTH:
            begin
                // empty glyph: skip the ink width, it stays cleared
                if (!wait_reg && sts.rcb_zero)
                begin
                    res_next   = ST_STARTED;
                    state_next = S_OUTW;
                end
                else if (!wait_reg)
                begin
                    cmd.fetch_start = 1'b1;
                    cmd.fetch_kind  = FK_WIDTH;
                    wait_next       = 1'b1;
                end
                else if (sts.fetch_done)
                begin
                    wait_next  = 1'b0;
                    res_next   = ST_STARTED;
                    state_next = S_OUTW;
                end
            end
            S_STEP:
            begin
                if (!sts.active)
                begin
                    res_next   = ST_IDLE;
                    state_next = S_OUTW;
                end
                else if (sts.need_run)
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    res_next   = ST_PIXEL;
                    state_next = S_OUTW;
                end
            end
            S_OUTW:
            begin
                if (sts.slot_free)
                begin
                    cmd.commit     = 1'b1;
                    cmd.res_status = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            res_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            res_reg   <= res_next;
        end
    end

endmodule

/* sv/rlgd_dp.sv */
// Datapath for the run-length glyph decoder: header, glyph state, result register.
// Depends on rlgd_pkg and rlgd_fetch; steered by rlgd_ctrl through cmd_t.
module rlgd_dp
    import rlgd_pkg::*;
#(
    parameter int FONT_BYTES = 4096
)(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output sts_t    sts,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);
    localparam int AW = $clog2(FONT_BYTES);
    localparam int PW = AW + 3;

    item_t                 cap_reg;
    logic [7:0]            hdr_reg [HDR_LEN];
    logic [2:0]            hdr_idx_reg;
    logic [2:0]            kind_reg;
    logic [31:0]           offset_reg;
    logic [PW-1:0]         ptr_reg;
    logic                  colour_reg;
    logic [3:0]            rcb_reg;
    logic [10:0]           ink_w_reg;
    logic [RUN_LEFT_W-1:0] run_val_reg;
    logic                  active_reg;
    logic [RUN_LEFT_W-1:0] run_left_reg;
    logic [10:0]           ink_cols_reg;
    logic [11:0]           cols_done_reg;
    logic [11:0]           cols_total_reg;
    logic [7:0]            row_reg;
    logic [7:0]            height_reg;
    logic [15:0]           pen_x_reg;
    logic [15:0]           top_y_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic [PW-1:0] f_pos;
    logic [5:0]    f_n;
    logic          f_done;
    logic [31:0]   f_value;
    logic [PW-1:0] f_end;
    logic [7:0]    code_diff;
    logic [15:0]   tab_prod;
    logic [15:0]   tab_size;
    logic [31:0]   off_pos;
    logic [31:0]   data_start;
    logic [11:0]   adv;
    logic          in_ink;
    logic [8:0]    row_inc;
    logic          row_wrap;
    logic [11:0]   cols_next;
    logic          colour_now;
    result_t       res_new;

    rlgd_fetch #(.FONT_BYTES(FONT_BYTES)) u_fetch (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd.write),
        .wr_addr (AW'(item.mem_address)),
        .wr_data (item.mem_byte),
        .start   (cmd.fetch_start),
        .pos     (f_pos),
        .nbits   (f_n),
        .done    (f_done),
        .value   (f_value),
        .end_pos (f_end)
    );

    always_comb
    begin
        code_diff  = cap_reg.glyph_code - hdr_reg[1];
        tab_prod   = code_diff * hdr_reg[4];
        tab_size   = hdr_reg[4] * hdr_reg[2];
        off_pos    = 32'(HDR_LEN * 8) + {16'd0, tab_prod};
        data_start = 32'(({1'b0, tab_size} + 17'(BYTE_ROUND)) >> 3) + 32'(HDR_LEN)
                     + offset_reg;
        case (cmd.fetch_kind)
            FK_HDR:
            begin
                f_pos = PW'({hdr_idx_reg, 3'b000});
                f_n   = 6'd8;
            end
            FK_OFFSET:
            begin
                f_pos = off_pos[PW-1:0];
                f_n   = hdr_reg[4][5:0];
            end
            FK_COLOUR:
            begin
                f_pos = ptr_reg;
                f_n   = 6'd1;
            end
            FK_RCB:
            begin
                f_pos = ptr_reg;
                f_n   = 6'(RUN_WIDTH_BITS);
            end
            FK_WIDTH:
            begin
                f_pos = ptr_reg;
                f_n   = 6'(INK_WIDTH_BITS);
            end
            default:
            begin
                f_pos = ptr_reg;
                f_n   = {2'b00, rcb_reg};
            end
        endcase
    end

    always_comb
    begin
        sts.fetch_done = f_done;
        sts.hdr_last   = (hdr_idx_reg == 3'(HDR_LEN - 1));
        sts.reject     = (cap_reg.glyph_code < hdr_reg[1])
                         || ({1'b0, cap_reg.glyph_code} >= ({1'b0, hdr_reg[1]}
                                                            + {1'b0, hdr_reg[2]}))
                         || (hdr_reg[4] < 8'(MIN_OFFSET_BITS));
        sts.nbits_big  = (hdr_reg[4] > 8'(MAX_FIELD_BITS));
        sts.rcb_zero   = (rcb_reg == 4'd0);
        sts.active     = active_reg;
        in_ink         = (cols_done_reg < {1'b0, ink_cols_reg});
        sts.need_run   = in_ink && (run_left_reg == '0);
        sts.slot_free  = !result_valid_reg || result_ready;
    end

    always_comb
    begin
        adv        = {1'b0, ink_w_reg} + (cap_reg.with_spacing ? {4'd0, hdr_reg[3]} : 12'd0);
        row_inc    = {1'b0, row_reg} + 9'd1;
        row_wrap   = (row_inc >= {1'b0, height_reg});
        cols_next  = cols_done_reg + {11'd0, row_wrap};
        colour_now = (run_left_reg == '0) ? !colour_reg : colour_reg;
        res_new    = '0;
        res_new.status = cmd.res_status;
        case (cmd.res_status)
            ST_STARTED: res_new.advance_width = adv;
            ST_PIXEL:
            begin
                res_new.pixel_x     = pen_x_reg + {4'd0, cols_done_reg};
                res_new.pixel_y     = top_y_reg + {8'd0, row_reg};
                res_new.pixel_on    = in_ink ? colour_now : 1'b1;
                res_new.final_pixel = (cols_next >= cols_total_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            hdr_idx_reg      <= '0;
            run_left_reg     <= '0;
            colour_reg       <= 1'b0;
            rcb_reg          <= '0;
            ptr_reg          <= '0;
            ink_cols_reg     <= '0;
            cols_done_reg    <= '0;
            cols_total_reg   <= '0;
            row_reg          <= '0;
            height_reg       <= '0;
            pen_x_reg        <= '0;
            top_y_reg        <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                hdr_idx_reg <= '0;
            end
            if (f_done)
            begin
                case (kind_reg)
                    FK_HDR:    hdr_idx_reg <= hdr_idx_reg + 3'd1;
                    FK_OFFSET: ;
                    FK_COLOUR:
                    begin
                        colour_reg <= f_value[0];
                        ptr_reg    <= f_end;
                    end
                    FK_RCB:
                    begin
                        rcb_reg <= f_value[3:0];
                        ptr_reg <= f_end;
                    end
                    default: ptr_reg <= f_end;
                endcase
            end
            if (cmd.set_ptr)
            begin
                ptr_reg <= {data_start[AW-1:0], 3'b000};
            end
            if (cmd.commit)
            begin
                result_valid_reg <= 1'b1;
                case (cmd.res_status)
                    ST_STARTED:
                    begin
                        ink_cols_reg   <= ink_w_reg;
                        cols_total_reg <= adv;
                        cols_done_reg  <= '0;
                        row_reg        <= '0;
                        run_left_reg   <= '0;
                        height_reg     <= hdr_reg[0];
                        pen_x_reg      <= cap_reg.origin_x;
                        top_y_reg      <= cap_reg.origin_y;
                        active_reg     <= (hdr_reg[0] != 8'd0) && (adv != 12'd0);
                    end
                    ST_REJECTED: active_reg <= 1'b0;
                    ST_PIXEL:
                    begin
                        if (in_ink)
                        begin
                            // start a new run: toggle and load its length
                            if (run_left_reg == '0)
                            begin
                                run_left_reg <= run_val_reg;
                                colour_reg   <= !colour_reg;
                            end
                            else
                            begin
                                run_left_reg <= run_left_reg - 1'b1;
                            end
                        end
                        row_reg       <= row_wrap ? 8'd0 : row_inc[7:0];
                        cols_done_reg <= cols_next;
                        if (cols_next >= cols_total_reg)
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_reg    <= item;
            offset_reg <= '0;
            ink_w_reg  <= '0;
        end
        if (cmd.fetch_start)
        begin
            kind_reg <= cmd.fetch_kind;
        end
        if (f_done)
        begin
            case (kind_reg)
                FK_HDR:    hdr_reg[hdr_idx_reg] <= f_value[7:0];
                FK_OFFSET: offset_reg <= f_value;
                FK_WIDTH:  ink_w_reg <= f_value[10:0];
                FK_RUN:    run_val_reg <= f_value[RUN_LEFT_W-1:0];
                default: ;
            endcase
        end
        if (cmd.commit)
        begin
            result_reg <= res_new;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/run_length_glyph_decoder.sv */
// Run-length glyph decoder: a packed bitmap font is loaded byte by byte,
// then glyphs are opened and drawn one pixel per step item.
//
// Input channel item_valid/item_ready/item carries write, start and step
// items. A write takes effect in the transfer cycle and gives no result.
// A start reads the five header bytes and answers a reject at once if the
// code is out of range or the offset entry is under two bits wide. Else it
// reads the offset table entry (skipped when wider than 32 bits), then the
// glyph's colour, run width and, for a nonzero run width, ink width, and
// answers with the advance width. Each field comes from the bit reader.
// A step gives one pixel, or an idle status when no glyph is active; when a
// new run begins its length is read first.
// Result channel result_valid/result_ready/result holds the answer in an
// output register; when the receiver stalls, the next item is not finished
// until the register frees. One item is worked on at a time.
// Reset clears the drawing counters and leaves no glyph active; the font store
// is not cleared and must be written before use.
module run_length_glyph_decoder
    import rlgd_pkg::*;
#(
    parameter int FONT_BYTES = 4096
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);
    cmd_t cmd;
    sts_t sts;

    rlgd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (item.opcode),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    rlgd_dp #(.FONT_BYTES(FONT_BYTES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`include "run_length_glyph_decoder_assert.svh"

    `RLGD_ASSERT_NEXT(a_busy_after_start,
        item_valid && item_ready && (item.opcode == OP_START || item.opcode == OP_STEP),
        !item_ready, "ready must drop while a start or step is worked on")
    `RLGD_ASSERT_IMPLY(a_reject_no_width,
        result_valid && result.status == ST_REJECTED,
        result.advance_width == 12'd0, "rejected glyph must report zero width")
    `RLGD_ASSERT_IMPLY(a_final_only_pixel,
        result_valid && result.status != ST_PIXEL,
        !result.final_pixel && !result.pixel_on, "pixel flags set on a non-pixel result")

endmodule

/* bench/glyph_checker.sv */
// Checker for the run-length glyph decoder: watches both channels, predicts
// each result from its own copy of the font store and glyph state.
// Depends on rlgd_pkg.
module glyph_checker
    import rlgd_pkg::*;
#(
    parameter int FONT_BYTES = 4096
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      pending_count,
    output int      pixels_seen,
    output int      starts_seen
);

    logic [7:0]  font_mem [FONT_BYTES];
    logic        drawing;
    logic [31:0] bit_ptr;
    int unsigned run_remaining;
    logic        colour;
    logic [3:0]  run_bits;
    int unsigned ink_cols;
    int unsigned cols_done;
    int unsigned cols_total;
    int unsigned row;
    int unsigned height;
    logic [15:0] pen_x;
    logic [15:0] top_y;
    result_t     expected_results[$];

    function automatic logic [7:0] font_byte(longint unsigned addr);
        return font_mem[addr % FONT_BYTES];
    endfunction

    function automatic int unsigned peek_bits(longint unsigned pos, int unsigned n);
        int unsigned acc;
        longint unsigned p;
        acc = 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            p = (pos + k) % (longint'(FONT_BYTES) * 8);
            acc = (acc << 1) | ((font_byte(p >> 3) >> (7 - (p & 7))) & 1);
        end
        return acc;
    endfunction

    function automatic int unsigned pull_bits(int unsigned n);
        int unsigned v;
        v = peek_bits(bit_ptr, n);
        bit_ptr = (longint'(bit_ptr) + n) % (longint'(FONT_BYTES) * 8);
        return v;
    endfunction

    function automatic result_t predict_start(item_t it);
        result_t r;
        int unsigned first, count, spacing, nbits, offset, width, adv;
        longint unsigned data_start;
        r = '0;
        first = font_byte(1);
        count = font_byte(2);
        spacing = font_byte(3);
        nbits = font_byte(4);
        offset = 0;
        width = 0;
        drawing = 1'b0;
        if (it.glyph_code < first || it.glyph_code >= first + count
            || nbits < MIN_OFFSET_BITS)
        begin
            r.status = ST_REJECTED;
            return r;
        end
        if (nbits <= MAX_FIELD_BITS)
            offset = peek_bits(HDR_LEN * 8 + longint'(it.glyph_code - first) * nbits, nbits);
        data_start = ((longint'(nbits) * count + 7) >> 3) + HDR_LEN + offset;
        bit_ptr = (data_start % FONT_BYTES) * 8;
        colour = pull_bits(1);
        run_bits = pull_bits(RUN_WIDTH_BITS);
        if (run_bits != 0)
            width = pull_bits(INK_WIDTH_BITS);
        adv = width + (it.with_spacing ? spacing : 0);
        ink_cols = width;
        cols_total = adv;
        cols_done = 0;
        row = 0;
        run_remaining = 0;
        height = font_byte(0);
        pen_x = it.origin_x;
        top_y = it.origin_y;
        drawing = (height != 0) && (cols_total != 0);
        r.status = ST_STARTED;
        r.advance_width = adv[11:0];
        starts_seen++;
        return r;
    endfunction

    function automatic result_t predict_pixel();
        result_t r;
        r = '0;
        if (!drawing)
        begin
            r.status = ST_IDLE;
            return r;
        end
        r.pixel_x = pen_x + cols_done[15:0];
        r.pixel_y = top_y + row[15:0];
        if (cols_done < ink_cols)
        begin
            if (run_remaining == 0)
            begin
                run_remaining = pull_bits(run_bits) + 1;
                colour = ~colour;
            end
            r.pixel_on = colour;
            run_remaining--;
        end
        else
            r.pixel_on = 1'b1;
        row++;
        if (row >= height)
        begin
            row = 0;
            cols_done++;
        end
        r.status = ST_PIXEL;
        if (cols_done >= cols_total)
        begin
            drawing = 1'b0;
            r.final_pixel = 1'b1;
        end
        pixels_seen++;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            drawing <= 1'b0;
            fail_count = 0;
            pixels_seen = 0;
            starts_seen = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", result.status, -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.advance_width !== want.advance_width)
                        report_mismatch("advance_width", result.advance_width,
                                        want.advance_width);
                    if (result.pixel_x !== want.pixel_x)
                        report_mismatch("pixel_x", result.pixel_x, want.pixel_x);
                    if (result.pixel_y !== want.pixel_y)
                        report_mismatch("pixel_y", result.pixel_y, want.pixel_y);
                    if (result.pixel_on !== want.pixel_on)
                        report_mismatch("pixel_on", result.pixel_on, want.pixel_on);
                    if (result.final_pixel !== want.final_pixel)
                        report_mismatch("final_pixel", result.final_pixel, want.final_pixel);
                end
            end
            if (item_valid && item_ready)
            begin
                case (item.opcode)
                    OP_WRITE: font_mem[item.mem_address % FONT_BYTES] = item.mem_byte;
                    OP_START: expected_results.push_back(predict_start(item));
                    OP_STEP:  expected_results.push_back(predict_pixel());
                    default: ;
                endcase
            end
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the glyph decoder bench: builds fonts, drives items with random
// gaps and stalls, and reports the verdict. Depends on rlgd_pkg,
// run_length_glyph_decoder and glyph_checker.
module testbench;
    import rlgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    int      fail_count;
    int      pending_count;
    int      pixels_seen;
    int      starts_seen;
    int      idle_cycles = 0;
    int      items_sent;
    logic    stall_free = 1'b0;

    run_length_glyph_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    glyph_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .pixels_seen  (pixels_seen),
        .starts_seen  (starts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random, except in no-stall stretches.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_free <= ~stall_free;
        result_ready <= stall_free ? 1'b1 : (gap_length() == 0);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Valid stays high into the next item when there is no gap.
    task automatic send_item(item_t it);
        int gap;
        gap = stall_free ? 0 : gap_length();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_byte(int addr, int value);
        item_t it;
        it = '0;
        it.opcode = OP_WRITE;
        it.mem_address = 12'(addr);
        it.mem_byte = 8'(value);
        send_item(it);
    endtask

    task automatic start_glyph(int code, bit spacing, logic [15:0] ox, logic [15:0] oy);
        item_t it;
        it = $urandom();
        it.opcode = OP_START;
        it.glyph_code = 8'(code);
        it.with_spacing = spacing;
        it.origin_x = ox;
        it.origin_y = oy;
        send_item(it);
    endtask

    task automatic step_pixel();
        item_t it;
        it = $urandom();
        it.opcode = OP_STEP;
        send_item(it);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Fill a small font: header, offset table, then glyph data with random runs.
    // Glyph data is kept short; every byte the decoder can touch is written.
    task automatic load_font(int height, int first, int count, int spacing, int nbits);
        int table_bytes;
        int data_base;
        int glyph_len;
        int off;
        int slot_bits;
        write_byte(0, height);
        write_byte(1, first);
        write_byte(2, count);
        write_byte(3, spacing);
        write_byte(4, nbits);
        table_bytes = (nbits * count + 7) / 8;
        data_base = HDR_LEN + table_bytes;
        glyph_len = 24;
        slot_bits = nbits > 32 ? 0 : nbits;
        // Build table entries bitwise through a shadow byte image.
        for (int b = 0; b < table_bytes; b++)
        begin
            int v;
            v = 0;
            for (int k = 0; k < 8; k++)
            begin
                int bitpos, g, inbit, bitval;
                bitpos = b * 8 + k;
                bitval = 0;
                if (slot_bits != 0)
                begin
                    g = bitpos / slot_bits;
                    inbit = bitpos % slot_bits;
                    off = g * glyph_len;
                    if (g < count && slot_bits - 1 - inbit < 31)
                        bitval = (off >> (slot_bits - 1 - inbit)) & 1;
                end
                v = (v << 1) | bitval;
            end
            write_byte(HDR_LEN + b, v);
        end
        for (int a = data_base; a < data_base + glyph_len * (count == 0 ? 1 : count) + 8; a++)
        begin
            if (a - data_base < glyph_len * count && (a - data_base) % glyph_len == 0)
                // colour bit, run width, top of ink width (kept small)
                write_byte(a, {1'($urandom_range(0, 1)), 4'($urandom_range(0, 3)), 3'b000});
            else if (a - data_base < glyph_len * count && (a - data_base) % glyph_len == 1)
                write_byte(a, {3'($urandom_range(0, 0)), 5'($urandom_range(0, 3))} );
            else
                write_byte(a, $urandom_range(0, 255));
        end
    endtask

    task automatic draw_glyph(int code, int max_steps);
        start_glyph(code, $urandom_range(0, 1), $urandom(), $urandom());
        for (int s = 0; s < max_steps; s++)
            step_pixel();
    endtask

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle step, header extremes, rejects, wide offsets, wrap.
        step_pixel();
        write_byte(0, 4);
        write_byte(1, 255);
        write_byte(2, 1);
        write_byte(3, 255);
        write_byte(4, 0);
        start_glyph(255, 1, 16'h7fff, 16'h8000);
        write_byte(4, 1);
        start_glyph(255, 1, 16'h7fff, 16'h8000);
        write_byte(4, 255);
        start_glyph(0, 0, 0, 0);
        // offset width over 32 reads offset 0; data then sits after 32 table bytes
        for (int a = 5; a < 48; a++)
            write_byte(a, a == 37 ? 8'h00 : 8'hff);
        write_byte(4095, 8'ha5);
        start_glyph(255, 1, 16'hffff, 16'hffff);
        step_pixel();
        step_pixel();
        write_byte(0, 0);
        start_glyph(255, 0, 0, 0);
        step_pixel();
        wait_drained();

        // Cover the window that glyphs with truncated offsets can run into.
        for (int a = 48; a < 320; a++)
            write_byte(a, $urandom_range(0, 255));

        // Random phase: fonts of varying shape, mostly full glyphs with noise.
        while (items_sent < 950)
        begin
            int height, first, count, nbits;
            height = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6);
            first = $urandom_range(0, 250);
            count = $urandom_range(0, 5);
            nbits = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(8, 16);
            load_font(height, first, count, $urandom_range(0, 3), nbits);
            for (int g = 0; g < 8; g++)
            begin
                case ($urandom_range(0, 9))
                    0: start_glyph($urandom_range(0, 255), $urandom_range(0, 1),
                                   $urandom(), $urandom());
                    1: step_pixel();
                    2:
                    begin
                        it = $urandom();
                        it.opcode = 2'd3;
                        send_item(it);
                    end
                    default: draw_glyph(first + $urandom_range(0, count),
                                        $urandom_range(1, 60));
                endcase
            end
            wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("ran %0d items: %0d glyph starts predicted, %0d pixels compared",
                 items_sent, starts_seen, pixels_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* run_length_glyph_decoder.f */
+incdir+sv
sv/rlgd_pkg.sv
sv/rlgd_fetch.sv
sv/rlgd_ctrl.sv
sv/rlgd_dp.sv
sv/run_length_glyph_decoder.sv
bench/glyph_checker.sv
bench/testbench.sv
